@@ rtl/core/preemptive_priority_scheduler_top_macros.svh @@
// assertion macros for the preemptive priority scheduler
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define PS_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define PS_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`else

`define PS_ASSERT_RUN(label, prop, msg)
`define PS_ASSERT_ALL(label, prop, msg)

`endif

`endif

@@ rtl/core/psched_pkg.sv @@
// shared types and constants of the preemptive priority scheduler
package psched_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 16;

  // operation codes
  localparam logic OP_ADMIT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ADMITTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RAN      = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [7:0]  process_id;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  running_id;
    logic [31:0] completion_time;
    logic [31:0] turnaround_time;
    logic [31:0] waiting_time;
  } out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [31:0] arrival;
  } slot_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

@@ rtl/core/psched_datapath.sv @@
// slot table, scan comparator, time base and result register
module psched_datapath #(
  parameter int unsigned TableSlots = psched_pkg::TABLE_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psched_pkg::in_t       in_data_i,
  input  psched_pkg::ctrl_cmd_t cmd_i,
  output psched_pkg::dp_sts_t   sts_o,
  output psched_pkg::out_t      out_data_o
);
  import psched_pkg::*;

  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSlots - 1);

  in_t                   item_q;
  logic [IdxW-1:0]       cnt_q;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  slot_t                 rd_data_q;
  slot_t                 slot_mem_q [TableSlots];
  logic [TableSlots-1:0] valid_q;
  logic                  best_found_q;
  logic [IdxW-1:0]       best_idx_q;
  slot_t                 best_q;
  logic                  free_found_q;
  logic [IdxW-1:0]       free_idx_q;
  logic [31:0]           time_q;
  logic [31:0]           tat_q;
  out_t                  out_q;

  logic            cand_valid;
  logic            cand_better;
  logic            is_tick;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  slot_t           wr_data;
  logic            set_vld;
  logic            clr_vld;
  out_t            out_d;

  // scan comparator: priority first, then id, earlier slot wins a full tie
  assign cand_valid  = valid_q[rd_idx_q];
  assign cand_better = cand_valid &&
                       (!best_found_q ||
                        (rd_data_q.prio < best_q.prio) ||
                        ((rd_data_q.prio == best_q.prio) && (rd_data_q.id < best_q.id)));

  assign is_tick = (item_q.operation == OP_TICK);
  assign sts_o.scan_last = (cnt_q == LastIdx);

  // commit decisions
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = best_idx_q;
    wr_data = best_q;
    set_vld = 1'b0;
    clr_vld = 1'b0;
    out_d   = '0;
    if (!is_tick) begin
      if (free_found_q) begin
        wr_en             = cmd_i.commit;
        wr_idx            = free_idx_q;
        wr_data.id        = item_q.process_id;
        wr_data.prio      = item_q.priority_level;
        wr_data.remaining = item_q.burst_length;
        wr_data.burst     = item_q.burst_length;
        wr_data.arrival   = time_q;
        set_vld           = cmd_i.commit;
        out_d.status      = ST_ADMITTED;
      end else begin
        out_d.status = ST_FULL;
      end
    end else if (!best_found_q) begin
      out_d.status = ST_IDLE;
    end else if (best_q.remaining > 16'd1) begin
      wr_en             = cmd_i.commit;
      wr_data.remaining = best_q.remaining - 16'd1;
      out_d.status      = ST_RAN;
      out_d.running_id  = best_q.id;
    end else begin
      clr_vld               = cmd_i.commit;
      out_d.status          = ST_FINISHED;
      out_d.running_id      = best_q.id;
      out_d.completion_time = time_q + 32'd1;
      out_d.turnaround_time = tat_q;
      out_d.waiting_time    = tat_q - {16'd0, best_q.burst};
    end
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_idx] <= wr_data;
    end
    rd_data_q <= slot_mem_q[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      time_q       <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        cnt_q        <= '0;
        best_found_q <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (rd_vld_q && cand_better) begin
          best_found_q <= 1'b1;
        end
        if (rd_vld_q && !cand_valid) begin
          free_found_q <= 1'b1;
        end
      end
      if (set_vld) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (clr_vld) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.commit && is_tick) begin
        time_q <= time_q + 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.start) begin
      item_q <= in_data_i;
    end
    if (rd_vld_q && cand_better) begin
      best_idx_q <= rd_idx_q;
      best_q     <= rd_data_q;
    end
    if (rd_vld_q && !cand_valid && !free_found_q && !cmd_i.start) begin
      free_idx_q <= rd_idx_q;
    end
    tat_q <= time_q + 32'd1 - best_q.arrival;
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/core/psched_ctrl.sv @@
// sequencing state machine and channel handshakes
module psched_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  psched_pkg::dp_sts_t   sts_i,
  output psched_pkg::ctrl_cmd_t cmd_o
);
  import psched_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LAST  = 5'b00100,
    S_CALC  = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/preemptive_priority_scheduler_top.sv @@
// preemptive priority scheduler top level: controller plus slot table datapath
// an accepted transaction passes slot scan, final compare, time arithmetic and commit; the commit
// waits while a result is stalled downstream, no new transaction is taken before it, and the slot scan
// reads one table entry per cycle through the single memory read port
// reset clears valid bits, current time and control; slot contents stay unknown until written
`include "preemptive_priority_scheduler_top_macros.svh"
module preemptive_priority_scheduler_top #(
  parameter int unsigned TableSlots = psched_pkg::TABLE_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  psched_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output psched_pkg::out_t out_data_o
);
  import psched_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: idle, slot scan, final compare, time arithmetic, commit
  psched_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: slot memory, best and free slot trackers, time base, result register
  psched_datapath #(
    .TableSlots (TableSlots)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // an accepted transaction keeps the block busy on the next cycle
  `PS_ASSERT_RUN(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")
  // a commit never overwrites a result still waiting downstream
  `PS_ASSERT_ALL(a_no_overwrite, cmd.commit |-> !(out_valid_o && out_stall_i), "pending result lost")
  // the scan ends right after the last slot
  `PS_ASSERT_RUN(a_scan_stops, (cmd.scan && sts.scan_last) |=> !cmd.scan, "scan ran past table")
  // a commit always presents a result on the next cycle
  `PS_ASSERT_RUN(a_commit_shows, cmd.commit |=> out_valid_o, "commit without result")

endmodule
